// ===== src/tom_pkg.sv =====
// Shared types, register codes and the sine table generator for the tone mixer.
// No dependencies; the mixer top level and its waveform unit import it.
package tom_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int WINDOW_W   = 24;
    localparam int SAMPLE_W   = 8;
    localparam int OFFSET_W   = 10;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SAW    = 2'd1,
        WAVE_SQUARE = 2'd2
    } t_wave_kind;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_WAVE_KIND    = 3'd0,
        REG_PHASE_STEP   = 3'd1,
        REG_AMPLITUDE    = 3'd2,
        REG_WINDOW_START = 3'd3,
        REG_WINDOW_END   = 3'd4
    } t_cfg_reg;

    // First-quadrant sine magnitude in Q0.15 for m/2^qbits of a quarter turn.
    // Taylor series through x^13 with every term truncated; elaboration only.
    function automatic logic [14:0] quarter_sine(input int unsigned m, input int unsigned qbits);
        logic [63:0]        theta;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        theta = (HALF_PI_Q30 * 64'(m)) >> qbits;
        x2    = (theta * theta) >> 30;
        term  = theta;
        sum   = signed'(theta);
        term  = ((term * x2) >> 30) / 64'd6;
        sum   = sum - signed'(term);
        term  = ((term * x2) >> 30) / 64'd20;
        sum   = sum + signed'(term);
        term  = ((term * x2) >> 30) / 64'd42;
        sum   = sum - signed'(term);
        term  = ((term * x2) >> 30) / 64'd72;
        sum   = sum + signed'(term);
        term  = ((term * x2) >> 30) / 64'd110;
        sum   = sum - signed'(term);
        term  = ((term * x2) >> 30) / 64'd156;
        sum   = sum + signed'(term);
        if (sum < 0) begin
            v = 64'd0;
        end else begin
            v = (unsigned'(sum) + 64'd16384) >> 15;
        end
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

endpackage

// ===== src/tom_wave.sv =====
// Waveform unit: signed tone offset for one phase value (sine table, saw, square).
// Depends on tom_pkg for the wave codes and the quarter-sine generator.
module tom_wave #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_INDEX_BITS = 10
) (
    input  tom_pkg::t_wave_kind                 i_kind,
    input  logic [tom_pkg::SAMPLE_W-1:0]        i_amplitude,
    input  logic [PHASE_BITS-1:0]               i_phase,
    output logic signed [tom_pkg::OFFSET_W-1:0] o_offset
);
    import tom_pkg::*;

    localparam int QBITS = SINE_INDEX_BITS - 2;
    localparam int QLEN  = 2 ** QBITS;
    localparam logic [14:0] PEAK = quarter_sine(QLEN, QBITS);
    localparam int SAW_W = PHASE_BITS + 10;
    localparam logic signed [SAW_W-1:0] SAW_BIAS = SAW_W'({PHASE_BITS{1'b1}});

    logic [14:0]                  w_qlut [QLEN];
    logic [SINE_INDEX_BITS-1:0]   w_k;
    logic [QBITS-1:0]             w_r;
    logic [QBITS-1:0]             w_m;
    logic [14:0]                  w_mag;
    logic signed [15:0]           w_sine;
    logic signed [24:0]           w_sine_prod;
    logic signed [24:0]           w_sine_bias;
    logic signed [OFFSET_W-1:0]   w_sine_off;
    logic signed [PHASE_BITS:0]   w_saw_d;
    logic signed [SAW_W-1:0]      w_saw_prod;
    logic signed [SAW_W-1:0]      w_saw_bias;
    logic signed [OFFSET_W-1:0]   w_saw_off;
    logic signed [OFFSET_W-1:0]   w_sq_off;

    for (genvar g = 0; g < QLEN; g++) begin : g_qlut
        assign w_qlut[g] = quarter_sine(g, QBITS);
    end

    // Quadrants 1 and 3 read the table mirrored; the quarter-turn peak sits past its end.
    assign w_k   = i_phase[PHASE_BITS-1 -: SINE_INDEX_BITS];
    assign w_r   = w_k[QBITS-1:0];
    assign w_m   = w_k[QBITS] ? (QBITS'(0) - w_r) : w_r;
    assign w_mag = (w_k[QBITS] && (w_r == '0)) ? PEAK : w_qlut[w_m];
    assign w_sine = w_k[QBITS+1] ? -signed'({1'b0, w_mag}) : signed'({1'b0, w_mag});

    // Round toward zero: bias negative products before the arithmetic shift.
    assign w_sine_prod = signed'({1'b0, i_amplitude}) * w_sine;
    assign w_sine_bias = w_sine_prod + (w_sine_prod[24] ? 25'sd32767 : 25'sd0);
    assign w_sine_off  = w_sine_bias[24:15];

    // 2*phase - 2^PHASE_BITS as a signed word
    assign w_saw_d    = signed'({~i_phase[PHASE_BITS-1], i_phase[PHASE_BITS-2:0], 1'b0});
    assign w_saw_prod = signed'({1'b0, i_amplitude}) * w_saw_d;
    assign w_saw_bias = w_saw_prod + (w_saw_prod[SAW_W-1] ? SAW_BIAS : '0);
    assign w_saw_off  = w_saw_bias[SAW_W-1:PHASE_BITS];

    assign w_sq_off = i_phase[PHASE_BITS-1] ? -signed'({2'b00, i_amplitude})
                                            : signed'({2'b00, i_amplitude});

    always_comb begin
        unique case (i_kind)
            WAVE_SINE:   o_offset = w_sine_off;
            WAVE_SAW:    o_offset = w_saw_off;
            WAVE_SQUARE: o_offset = w_sq_off;
            default:     o_offset = '0;
        endcase
    end

endmodule

// ===== src/tone_oscillator_mixer.sv =====
// Tone oscillator mixer top level: counters, config registers, two-register pipeline.
// Depends on tom_pkg and tom_wave.
//
//   channel   direction  handshake                 payload
//   in        sink       i_in_valid / o_in_ready   i_base_sample, i_restart
//   out       source     o_out_valid / i_out_ready o_mixed_sample, o_in_window
//   cfg       sink       i_cfg_we (no wait)        i_cfg_addr, i_cfg_wdata
//
// One word per cycle sustained while the output takes each result; a word taken passes
// through the input register, then the result register after table lookup, multiply and clamp.
// Reset clears the counters, config registers and valid flags; no clearing pass.
// A stalled result holds the result register; the input register still takes a
// word, so input stalls only when both registers are full and the output waits.
module tone_oscillator_mixer #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_INDEX_BITS = 10,
    parameter int INDEX_BITS      = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tom_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [tom_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [tom_pkg::SAMPLE_W-1:0]     i_base_sample,
    input  logic                             i_restart,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tom_pkg::SAMPLE_W-1:0]     o_mixed_sample,
    output logic                             o_in_window
);
    import tom_pkg::*;

    localparam int CMP_W = (INDEX_BITS > WINDOW_W) ? INDEX_BITS : WINDOW_W;

    t_wave_kind              r_wave_kind;
    logic [CFG_DATA_W-1:0]   r_phase_step;
    logic [SAMPLE_W-1:0]     r_amplitude;
    logic [WINDOW_W-1:0]     r_window_start;
    logic [WINDOW_W-1:0]     r_window_end;

    logic [INDEX_BITS-1:0]   r_sample_index;
    logic [PHASE_BITS-1:0]   r_phase_acc;

    logic                    r_s1_vld;
    logic [SAMPLE_W-1:0]     r_s1_base;
    logic [INDEX_BITS-1:0]   r_s1_index;
    logic [PHASE_BITS-1:0]   r_s1_phase;

    logic                    r_out_vld;
    logic [SAMPLE_W-1:0]     r_out_sample;
    logic                    r_out_window;
    logic [SAMPLE_W-1:0]     n_out_sample;

    logic                    w_out_free;
    logic                    w_s1_move;
    logic                    w_in_acc;
    logic [INDEX_BITS-1:0]   w_idx_now;
    logic [PHASE_BITS-1:0]   w_phase_now;
    logic                    w_s1_inside;
    logic signed [OFFSET_W-1:0] w_offset;
    logic signed [OFFSET_W:0]   w_sum;

    assign w_out_free = !r_out_vld || i_out_ready;
    assign w_s1_move  = r_s1_vld && w_out_free;
    assign o_in_ready = i_rst_n && (!r_s1_vld || w_out_free);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // A restart word is index zero at phase zero.
    assign w_idx_now   = i_restart ? '0 : r_sample_index;
    assign w_phase_now = i_restart ? '0 : r_phase_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_kind    <= WAVE_SINE;
            r_phase_step   <= '0;
            r_amplitude    <= '0;
            r_window_start <= '0;
            r_window_end   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WAVE_KIND:    r_wave_kind    <= t_wave_kind'(i_cfg_wdata[1:0]);
                REG_PHASE_STEP:   r_phase_step   <= i_cfg_wdata;
                REG_AMPLITUDE:    r_amplitude    <= i_cfg_wdata[SAMPLE_W-1:0];
                REG_WINDOW_START: r_window_start <= i_cfg_wdata[WINDOW_W-1:0];
                REG_WINDOW_END:   r_window_end   <= i_cfg_wdata[WINDOW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_index <= '0;
            r_phase_acc    <= '0;
            r_s1_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_sample_index <= w_idx_now + 1'b1;
                r_phase_acc    <= w_phase_now + PHASE_BITS'(r_phase_step);
                r_s1_vld       <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_base  <= i_base_sample;
            r_s1_index <= w_idx_now;
            r_s1_phase <= w_phase_now;
        end
        if (w_s1_move) begin
            r_out_sample <= n_out_sample;
            r_out_window <= w_s1_inside;
        end
    end

    assign w_s1_inside = (CMP_W'(r_s1_index) >= CMP_W'(r_window_start)) &&
                         (CMP_W'(r_s1_index) <  CMP_W'(r_window_end));

    tom_wave #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_INDEX_BITS (SINE_INDEX_BITS)
    ) u_wave (
        .i_kind      (r_wave_kind),
        .i_amplitude (r_amplitude),
        .i_phase     (r_s1_phase),
        .o_offset    (w_offset)
    );

    assign w_sum = signed'({3'b000, r_s1_base}) + (OFFSET_W + 1)'(w_offset);

    // Clamp to the unsigned sample range; outside the window pass the word through.
    always_comb begin
        priority if (!w_s1_inside) begin
            n_out_sample = r_s1_base;
        end else if (w_sum < 0) begin
            n_out_sample = '0;
        end else if (w_sum > 255) begin
            n_out_sample = '1;
        end else begin
            n_out_sample = w_sum[SAMPLE_W-1:0];
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_mixed_sample = r_out_sample;
    assign o_in_window    = r_out_window;

    a_restart_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_restart |=> r_sample_index == INDEX_BITS'(1))
        else $error("sample index not 1 after restart word");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !i_restart |=> r_sample_index == INDEX_BITS'($past(r_sample_index) + 1'b1))
        else $error("sample index did not advance by one");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && !w_in_acc |=> $stable(r_phase_acc))
        else $error("phase moved without an accepted word");

    a_pass_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_move && !w_s1_inside |=> o_mixed_sample == $past(r_s1_base) && !o_in_window)
        else $error("word outside window was altered");

endmodule
